// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define AST_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AST_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/bta_pkg.sv
package bta_pkg;

    // heap geometry, block size must be a power of two
    localparam int BLOCK_BYTES = 4096;
    localparam int MAX_BLOCKS  = 1024;

    localparam int SH    = $clog2(BLOCK_BYTES);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 32;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_CNT_W  = 11;
    localparam int ENT_W      = 3;

    localparam logic [CFG_CNT_W-1:0] BLKCNT_RST = CFG_CNT_W'(1024);

    // opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE  = 2'd1;
    localparam logic [ST_W-1:0] ST_MISALIGN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

    // table entry bit positions
    localparam int ENT_TAKEN = 0;
    localparam int ENT_FIRST = 1;
    localparam int ENT_NEXT  = 2;

    typedef struct packed {
        logic load;
        logic prep;
        logic scan;
        logic mark;
        logic clr_wr;
        logic free_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            alloc_bad;
        logic            free_bad;
        logic            misaligned;
        logic            found;
        logic            exhausted;
        logic            mark_last;
        logic            clr_last;
        logic            free_more;
    } t_sts;

endpackage

// File: rtl/block_table_heap_allocator_unit.sv
// sequence: allocate scans the entries in use, one table read a cycle, for a first free run,
//   then one write per run block; free reads and clears each chained entry; clear frees all
// throughput: one word at a time, bounded by the single table port; a new word is taken
//   while the previous result still waits in the output register
// reset: synchronous, active low; a sweep then marks every block free, ready low meanwhile
module block_table_heap_allocator_unit import bta_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [SIZE_W-1:0]     i_request_size,
    input  logic [ADDR_W-1:0]     i_release_address,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ADDR_W-1:0]     o_result_address,
    output logic [ST_W-1:0]       o_status
);

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: reset and clear sweeps, first-fit scan, run marking, chain walk, result hand-off
    bta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: config registers, block table memory, walk pointer and result word
    bta_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode),
        .i_request_size    (i_request_size),
        .i_release_address (i_release_address),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_result_address  (o_result_address),
        .o_status          (o_status)
    );

endmodule

// File: rtl/bta_ram.sv
module bta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bta_dp.sv
`include "assert_macros.svh"

module bta_dp import bta_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [SIZE_W-1:0]     i_request_size,
    input  logic [ADDR_W-1:0]     i_release_address,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [ADDR_W-1:0]     o_result_address,
    output logic [ST_W-1:0]       o_status
);

    logic [ADDR_W-1:0]    r_base;
    logic [CFG_CNT_W-1:0] r_block_count;
    logic [OP_W-1:0]      r_op;
    logic [SIZE_W-1:0]    r_size;
    logic [ADDR_W-1:0]    r_rel;
    logic [CNT_W-1:0]     r_ptr;
    logic [CNT_W-1:0]     r_run;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_chk_idx;
    logic                 r_chk_vld;
    logic [CNT_W-1:0]     r_first;
    logic [ADDR_W-1:0]    r_res_addr;
    logic [ST_W-1:0]      r_res_sts;
    logic [ADDR_W-1:0]    r_out_addr;
    logic [ST_W-1:0]      r_out_sts;

    logic [CNT_W-1:0]  blocks_n;
    logic [SIZE_W:0]   need;
    logic [ADDR_W-1:0] idx_full;
    logic [IDX_W-1:0]  ptr_idx;
    logic              issue;
    logic              taken;
    logic [CNT_W-1:0]  run_inc;
    logic              found;
    logic [CNT_W-1:0]  first_calc;
    logic              mark_last;
    logic [ENT_W-1:0]  entry;
    logic [CNT_W:0]    ptr_inc;
    logic              free_more;
    logic              clr_last;
    logic              misaligned;
    logic [ADDR_W-1:0] alloc_addr;
    logic              ram_we;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;

    // entries in use, capped at the table depth
    assign blocks_n = (32'(r_block_count) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                             : CNT_W'(r_block_count);

    // byte count rounded up to whole blocks
    assign need = ({1'b0, r_size} + (SIZE_W+1)'(BLOCK_BYTES - 1)) >> SH;

    assign idx_full   = (r_rel - r_base) >> SH;
    assign ptr_idx    = r_ptr[IDX_W-1:0];
    assign issue      = r_ptr < blocks_n;
    assign taken      = ram_rdata[ENT_TAKEN];
    assign run_inc    = r_run + CNT_W'(1);
    assign found      = r_chk_vld && !taken && (run_inc == r_rem);
    assign first_calc = r_chk_idx - r_run;
    assign mark_last  = r_rem == CNT_W'(1);
    assign ptr_inc    = {1'b0, r_ptr} + (CNT_W+1)'(1);
    assign free_more  = ram_rdata[ENT_NEXT] && (ptr_inc < {1'b0, blocks_n});
    assign clr_last   = ptr_idx == IDX_W'(MAX_BLOCKS - 1);
    assign misaligned = r_base[SH-1:0] != '0;
    assign alloc_addr = r_base + ADDR_W'({r_first, {SH{1'b0}}});

    always_comb begin
        entry            = '0;
        entry[ENT_TAKEN] = 1'b1;
        entry[ENT_FIRST] = r_ptr == r_first;
        entry[ENT_NEXT]  = !mark_last;
    end

    assign ram_we    = i_cmd.clr_wr || i_cmd.mark || i_cmd.free_wr;
    assign ram_wdata = i_cmd.mark ? entry : '0;

    bta_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ptr_idx),
        .i_wdata (ram_wdata),
        .i_raddr (ptr_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.alloc_bad  = (need == '0) || (need > (SIZE_W+1)'(blocks_n));
        o_sts.free_bad   = idx_full >= ADDR_W'(blocks_n);
        o_sts.misaligned = misaligned;
        o_sts.found      = found;
        o_sts.exhausted  = r_chk_vld && !found && (r_chk_idx == blocks_n - CNT_W'(1));
        o_sts.mark_last  = mark_last;
        o_sts.clr_last   = clr_last;
        o_sts.free_more  = free_more;
    end

    // configuration and walk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= '0;
            r_block_count <= BLKCNT_RST;
            r_ptr         <= '0;
            r_run         <= '0;
            r_rem         <= '0;
            r_chk_idx     <= '0;
            r_chk_vld     <= 1'b0;
            r_first       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BASE:  r_base <= ADDR_W'(i_cfg_data);
                    CFG_COUNT: r_block_count <= i_cfg_data[CFG_CNT_W-1:0];
                endcase
            end
            if (i_cmd.prep) begin
                r_run     <= '0;
                r_chk_vld <= 1'b0;
                r_rem     <= CNT_W'(need);
                r_ptr     <= (r_op == OP_FREE) ? CNT_W'(idx_full) : '0;
            end
            if (i_cmd.scan) begin
                // a hit ends the scan, no check stays pending
                r_chk_vld <= issue && !found;
                r_chk_idx <= r_ptr;
                if (r_chk_vld) begin
                    r_run <= taken ? '0 : run_inc;
                end
                if (found) begin
                    r_ptr   <= first_calc;
                    r_first <= first_calc;
                end else if (issue) begin
                    r_ptr <= ptr_inc[CNT_W-1:0];
                end
            end
            if (i_cmd.mark) begin
                r_ptr <= ptr_inc[CNT_W-1:0];
                r_rem <= r_rem - CNT_W'(1);
            end
            if (i_cmd.clr_wr) begin
                r_ptr <= clr_last ? '0 : ptr_inc[CNT_W-1:0];
            end
            if (i_cmd.free_wr && free_more) begin
                r_ptr <= ptr_inc[CNT_W-1:0];
            end
        end
    end

    // request and result words
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_size <= i_request_size;
            r_rel  <= i_release_address;
        end
        if (i_cmd.prep) begin
            r_res_addr <= '0;
            case (r_op)
                OP_ALLOC: r_res_sts <= ST_NOSPACE;
                OP_CLEAR: r_res_sts <= misaligned ? ST_MISALIGN : ST_OK;
                default:  r_res_sts <= ST_OK;
            endcase
        end
        if (i_cmd.mark && mark_last) begin
            r_res_addr <= alloc_addr;
            r_res_sts  <= ST_OK;
        end
        if (i_cmd.out_load) begin
            r_out_addr <= r_res_addr;
            r_out_sts  <= r_res_sts;
        end
    end

    assign o_result_address = r_out_addr;
    assign o_status         = r_out_sts;

    `AST_CHK(a_mark_in_range, i_cmd.mark |-> (r_ptr < blocks_n), "mark beyond table")
    `AST_CHK(a_chk_from_scan, r_chk_vld |-> $past(i_cmd.scan), "check without scan")

endmodule

// File: rtl/bta_ctrl.sv
`include "assert_macros.svh"

module bta_ctrl import bta_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_PREP = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_MARK = 4'd4;
    localparam logic [3:0] S_FRD  = 4'd5;
    localparam logic [3:0] S_FWR  = 4'd6;
    localparam logic [3:0] S_CLR  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;
    t_cmd       cmd;

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                case (i_sts.op)
                    OP_ALLOC: n_state = i_sts.alloc_bad ? S_DONE : S_SCAN;
                    OP_FREE:  n_state = i_sts.free_bad ? S_DONE : S_FRD;
                    OP_CLEAR: n_state = i_sts.misaligned ? S_DONE : S_CLR;
                    default:  n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (i_sts.found) begin
                    n_state = S_MARK;
                end else if (i_sts.exhausted) begin
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                cmd.mark = 1'b1;
                if (i_sts.mark_last) begin
                    n_state = S_DONE;
                end
            end
            S_FRD: begin
                n_state = S_FWR;
            end
            S_FWR: begin
                cmd.free_wr = 1'b1;
                n_state     = i_sts.free_more ? S_FRD : S_DONE;
            end
            S_CLR: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_vld;

    `AST_RST(a_rst_sweep, !i_rst_n |=> (r_state == S_INIT), "reset does not start sweep")
    `AST_CHK(a_accept_prep, (i_in_valid && o_in_ready) |=> (r_state == S_PREP), "accept lost")
    `AST_CHK(a_no_overwrite, cmd.out_load |-> (!r_out_vld || i_out_ready), "result overwritten")

endmodule
